[rtl/hdit_pkg.sv]
// ----------------------------------------------------------------------------
// hdit_pkg: shared types and constants of the dense index table
// Field widths, parameter defaults and result status codes.
// ----------------------------------------------------------------------------
package hdit_pkg;

  localparam int ADDR_W      = 64;
  localparam int CALL_KIND_W = 3;
  localparam int ENTRY_W     = 10;
  localparam int STATUS_W    = 2;
  localparam int KIND_MAX_W  = 8;
  localparam int CELL_W      = 16;

  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int DEF_BUCKET_BITS = 11;
  localparam int DEF_TAG_SHIFT   = 2;
  localparam int DEF_KIND_BITS   = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_FULL      = 2'd2,
    ST_ZERO_ADDR = 2'd3
  } status_e;

endpackage

[rtl/hdit_ram.sv]
// ----------------------------------------------------------------------------
// hdit_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hdit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hdit_match_cell.sv]
// ----------------------------------------------------------------------------
// hdit_match_cell: one slice of the search key
// Holds a slice of the key being looked up and extends the match chain
// from its neighbor with the compare of its slice of the stored entry.
// ----------------------------------------------------------------------------
module hdit_match_cell #(
  parameter int unsigned W = 16
) (
  input  logic         clk_i,
  input  logic         load_i,
  input  logic [W-1:0] key_i,
  input  logic [W-1:0] data_i,
  input  logic         match_i,
  output logic         match_o,
  output logic [W-1:0] key_o
);

  logic [W-1:0] key_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= key_i;
    end
  end

  assign match_o = match_i & (data_i == key_q);
  assign key_o   = key_q;

endmodule

[rtl/hashed_key_to_dense_index_table.sv]
// ----------------------------------------------------------------------------
// hashed_key_to_dense_index_table: chained hash table assigning dense indices
// Looks up (address, kind) keys and hands out indices in first-seen order.
// ----------------------------------------------------------------------------
// One key at a time: the input is ready only in the idle state, so a new key is
//   taken only after the previous result has moved to the output register.
// A lookup reads the bucket head, then walks the chain with a single read at a
//   time on the entry memories; a zero address skips the head read and the walk.
// Reset clears the entry count at once; no memory clearing pass is needed,
//   since stale bucket heads fail the count and bucket checks.
module hashed_key_to_dense_index_table
  import hdit_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int unsigned BUCKET_BITS = DEF_BUCKET_BITS,
  parameter int unsigned TAG_SHIFT   = DEF_TAG_SHIFT,
  parameter int unsigned KIND_BITS   = DEF_KIND_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ADDR_W-1:0]      instr_address_i,
  input  logic [CALL_KIND_W-1:0] call_kind_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ENTRY_W-1:0]     entry_index_o,
  output logic [STATUS_W-1:0]    status_o
);

  localparam int unsigned NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned LINK_W      = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KEY_W       = ADDR_W + KIND_BITS;
  localparam int unsigned NUM_CELLS   = (KEY_W + CELL_W - 1) / CELL_W;
  localparam int unsigned PAD_W       = NUM_CELLS * CELL_W;
  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_CMP,
    S_RESP
  } state_e;

  state_e                 state_q, state_d;
  logic [BUCKET_BITS-1:0] bucket_q, bucket_d;
  logic [LINK_W-1:0]      cur_q, cur_d;
  logic [LINK_W-1:0]      link_q, link_d;
  logic                   first_q, first_d;
  logic [LINK_W-1:0]      count_q, count_d;
  logic [ENTRY_W-1:0]     res_idx_q, res_idx_d;
  status_e                res_status_q, res_status_d;
  logic                   out_valid_q, out_valid_d;
  logic [ENTRY_W-1:0]     out_idx_q, out_idx_d;
  status_e                out_status_q, out_status_d;

  logic                   accept;
  logic [KIND_MAX_W-1:0]  kind_wide;
  logic [KIND_BITS-1:0]   kind_key;
  logic [BUCKET_BITS-1:0] bucket_in;

  logic                   head_re, head_we;
  logic [LINK_W-1:0]      head_rdata;
  logic                   rd_en, ins;
  logic [LINK_W-1:0]      rd_ptr;
  logic [KEY_W-1:0]       key_rdata;
  logic [LINK_W-1:0]      next_rdata;
  logic                   do_miss;
  logic [LINK_W-1:0]      miss_link;

  logic [PAD_W-1:0]       key_pad_in, data_pad, held_pad;
  logic [NUM_CELLS:0]     match;
  logic                   key_hit;
  logic [KEY_W-1:0]       held_key;
  logic                   bucket_ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign kind_wide  = KIND_MAX_W'(call_kind_i);
  assign kind_key   = kind_wide[KIND_BITS-1:0];
  assign bucket_in  = instr_address_i[TAG_SHIFT +: BUCKET_BITS];

  // Row of compare cells; the match bit ripples from the first slice to the last.
  assign key_pad_in = PAD_W'({kind_key, instr_address_i});
  assign data_pad   = PAD_W'(key_rdata);
  assign match[0]   = 1'b1;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    hdit_match_cell #(
      .W(CELL_W)
    ) u_cell (
      .clk_i  (clk_i),
      .load_i (accept),
      .key_i  (key_pad_in[i*CELL_W +: CELL_W]),
      .data_i (data_pad[i*CELL_W +: CELL_W]),
      .match_i(match[i]),
      .match_o(match[i+1]),
      .key_o  (held_pad[i*CELL_W +: CELL_W])
    );
  end

  assign key_hit   = match[NUM_CELLS];
  assign held_key  = held_pad[KEY_W-1:0];
  assign bucket_ok = (key_rdata[TAG_SHIFT +: BUCKET_BITS] == bucket_q);

  hdit_ram #(
    .WIDTH(LINK_W),
    .DEPTH(NUM_BUCKETS)
  ) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(bucket_q),
    .wdata_i(count_q),
    .re_i   (head_re),
    .raddr_i(bucket_in),
    .rdata_o(head_rdata)
  );

  hdit_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ins),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(held_key),
    .re_i   (rd_en),
    .raddr_i(rd_ptr[IDX_W-1:0]),
    .rdata_o(key_rdata)
  );

  hdit_ram #(
    .WIDTH(LINK_W),
    .DEPTH(MAX_ENTRIES)
  ) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (ins),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(miss_link),
    .re_i   (rd_en),
    .raddr_i(rd_ptr[IDX_W-1:0]),
    .rdata_o(next_rdata)
  );

  assign head_we = ins;

  always_comb begin
    state_d      = state_q;
    bucket_d     = bucket_q;
    cur_d        = cur_q;
    link_d       = link_q;
    first_d      = first_q;
    count_d      = count_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    head_re      = 1'b0;
    rd_en        = 1'b0;
    rd_ptr       = head_rdata;
    do_miss      = 1'b0;
    miss_link    = EMPTY_LINK;
    ins          = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          bucket_d = bucket_in;
          if (instr_address_i == '0) begin
            res_idx_d    = '0;
            res_status_d = ST_ZERO_ADDR;
            state_d      = S_RESP;
          end else begin
            head_re = 1'b1;
            state_d = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        // A head at or beyond the count was never written since reset.
        if (head_rdata < count_q) begin
          rd_en   = 1'b1;
          rd_ptr  = head_rdata;
          cur_d   = head_rdata;
          link_d  = head_rdata;
          first_d = 1'b1;
          state_d = S_CMP;
        end else begin
          do_miss = 1'b1;
        end
      end
      S_CMP: begin
        if (key_hit) begin
          res_idx_d    = ENTRY_W'(cur_q);
          res_status_d = ST_FOUND;
          state_d      = S_RESP;
        end else if (first_q && !bucket_ok) begin
          // The head is left over from before reset: the bucket is empty.
          do_miss = 1'b1;
        end else if (next_rdata < count_q) begin
          rd_en   = 1'b1;
          rd_ptr  = next_rdata;
          cur_d   = next_rdata;
          first_d = 1'b0;
        end else begin
          do_miss   = 1'b1;
          miss_link = link_q;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_idx_d    = res_idx_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_miss) begin
      state_d = S_RESP;
      if (count_q == EMPTY_LINK) begin
        res_idx_d    = '0;
        res_status_d = ST_FULL;
      end else begin
        ins          = 1'b1;
        res_idx_d    = ENTRY_W'(count_q);
        res_status_d = ST_INSERTED;
        count_d      = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bucket_q     <= '0;
      cur_q        <= '0;
      link_q       <= EMPTY_LINK;
      first_q      <= 1'b0;
      count_q      <= '0;
      res_idx_q    <= '0;
      res_status_q <= ST_FOUND;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_status_q <= ST_FOUND;
    end else begin
      state_q      <= state_d;
      bucket_q     <= bucket_d;
      cur_q        <= cur_d;
      link_q       <= link_d;
      first_q      <= first_d;
      count_q      <= count_d;
      res_idx_q    <= res_idx_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_idx_q    <= out_idx_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = out_idx_q;
  assign status_o      = out_status_q;

  a_insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins |-> (count_q < EMPTY_LINK))
    else $error("insertion into a full table");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins |=> (count_q == $past(count_q) + 1'b1))
    else $error("entry count did not advance after insertion");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (cur_q < count_q))
    else $error("chain walk reached an unwritten entry");

  a_error_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL || status_o == ST_ZERO_ADDR))
      |-> (entry_index_o == '0))
    else $error("error result with nonzero index");

endmodule

[tb/sv/hashed_key_to_dense_index_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_to_dense_index_table_tb: self-checking bench for the index table
// Sends (address, kind) keys through the input channel, keeps a software copy
// of the chained table to compute the expected index and status of each key,
// and compares every result against the oldest outstanding prediction. The
// random traffic mixes repeated keys, crowded buckets and zero addresses, and
// runs the table past its capacity.
// ----------------------------------------------------------------------------
module hashed_key_to_dense_index_table_tb;
  import hdit_pkg::*;

  localparam int unsigned NUM_ENTRIES  = DEF_MAX_ENTRIES;
  localparam int unsigned HASH_BITS    = DEF_BUCKET_BITS;
  localparam int unsigned HASH_SHIFT   = DEF_TAG_SHIFT;
  localparam int unsigned KIND_KEY_W   = DEF_KIND_BITS;
  localparam int unsigned NUM_BUCKETS  = 1 << HASH_BITS;
  localparam int unsigned NO_LINK      = NUM_ENTRIES;
  localparam int          RANDOM_KEYS  = 1750;
  localparam int          NUM_HOT      = 24;
  localparam int          STALL_LIMIT  = 6000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CALM_FIRST   = 700;
  localparam int          CALM_LAST    = 1000;

  typedef struct packed {
    logic [ADDR_W-1:0]      addr;
    logic [CALL_KIND_W-1:0] kind;
  } key_item_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] index;
    status_e            status;
  } lookup_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready_o;
  logic [ADDR_W-1:0]      instr_address = '0;
  logic [CALL_KIND_W-1:0] call_kind = '0;
  logic                   out_valid_o;
  logic                   out_ready = 1'b0;
  logic [ENTRY_W-1:0]     entry_index_o;
  logic [STATUS_W-1:0]    status_o;

  key_item_t      pending_keys[$];
  lookup_result_t expected_results[$];

  // Software copy of the table.
  logic [ADDR_W-1:0]     table_addr [NUM_ENTRIES];
  logic [KIND_KEY_W-1:0] table_kind [NUM_ENTRIES];
  int unsigned           table_next [NUM_ENTRIES];
  int unsigned           bucket_head[NUM_BUCKETS];
  int unsigned           used_entries;

  int sent_count    = 0;
  int results_seen  = 0;
  int mismatch_count = 0;
  int quiet_cycles  = 0;

  hashed_key_to_dense_index_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .instr_address_i(instr_address),
    .call_kind_i    (call_kind),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .entry_index_o  (entry_index_o),
    .status_o       (status_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Sequence position n gets a short window with no idling at all.
  function automatic bit idle_roll(input int n);
    return !(n >= CALM_FIRST && n < CALM_LAST) && ($urandom_range(99) < 6);
  endfunction

  // Looks the key up in the chain of its bucket and inserts it when missing.
  function automatic lookup_result_t lookup_or_insert(input key_item_t key);
    lookup_result_t        res;
    int unsigned           bucket;
    int unsigned           cur;
    int unsigned           steps;
    logic [KIND_KEY_W-1:0] kind;
    bit                    hit;
    res.index  = '0;
    res.status = ST_ZERO_ADDR;
    kind       = key.kind[KIND_KEY_W-1:0];
    hit        = 1'b0;
    if (key.addr != '0) begin
      bucket = 32'(key.addr[HASH_SHIFT +: HASH_BITS]);
      cur    = bucket_head[bucket];
      steps  = 0;
      while (!hit && cur < used_entries && cur < NUM_ENTRIES && steps < NUM_ENTRIES) begin
        if (table_addr[cur] == key.addr && table_kind[cur] == kind) begin
          hit = 1'b1;
        end else begin
          cur = table_next[cur];
          steps++;
        end
      end
      if (hit) begin
        res.index  = cur[ENTRY_W-1:0];
        res.status = ST_FOUND;
      end else if (used_entries >= NUM_ENTRIES) begin
        res.status = ST_FULL;
      end else begin
        table_addr[used_entries]  = key.addr;
        table_kind[used_entries]  = kind;
        table_next[used_entries]  = bucket_head[bucket];
        bucket_head[bucket]       = used_entries;
        res.index  = used_entries[ENTRY_W-1:0];
        res.status = ST_INSERTED;
        used_entries++;
      end
    end
    return res;
  endfunction

  // Input side: one key per transfer, the prediction is made on acceptance.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_results.push_back(lookup_or_insert({instr_address, call_kind}));
        sent_count++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_keys.size() > 0 && !idle_roll(sent_count)) begin
          in_valid      <= 1'b1;
          instr_address <= pending_keys[0].addr;
          call_kind     <= pending_keys[0].kind;
          void'(pending_keys.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each result transfer, stall at random, and watch for hangs.
  always @(posedge clk_i) begin
    lookup_result_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result index %0d status %0d with nothing outstanding",
                                    entry_index_o, status_o));
        end else begin
          exp_res = expected_results.pop_front();
          if (entry_index_o !== exp_res.index)
            report_mismatch($sformatf("result %0d: index %0d, predicted %0d",
                                      results_seen, entry_index_o, exp_res.index));
          if (status_o !== exp_res.status)
            report_mismatch($sformatf("result %0d: status %0d, predicted %0d",
                                      results_seen, status_o, exp_res.status));
        end
        results_seen++;
      end
      out_ready <= !idle_roll(results_seen);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    key_item_t                seen_keys[$];
    key_item_t                key;
    logic [HASH_BITS-1:0]     hot_bucket[NUM_HOT];
    logic [ADDR_W-1:0]        ones;
    int                       pick;

    used_entries = 0;
    for (int b = 0; b < NUM_BUCKETS; b++) bucket_head[b] = NO_LINK;
    ones = '1;

    // Directed keys: zero addresses, extreme addresses and kinds, repeats and
    // several distinct keys sharing the first bucket.
    pending_keys.push_back({64'h0, 3'd0});
    pending_keys.push_back({64'h0, 3'd7});
    pending_keys.push_back({64'h1, 3'd0});
    pending_keys.push_back({64'h1, 3'd0});
    pending_keys.push_back({64'h1, 3'd7});
    pending_keys.push_back({ones, 3'd7});
    pending_keys.push_back({ones, 3'd0});
    pending_keys.push_back({ones, 3'd7});
    pending_keys.push_back({64'h2, 3'd0});
    pending_keys.push_back({64'h2001, 3'd0});
    pending_keys.push_back({64'h1, 3'd7});
    pending_keys.push_back({64'h1, 3'd0});
    pending_keys.push_back({64'h8000_0000_0000_0000, 3'd3});
    pending_keys.push_back({64'h0000_0000_0000_1FFC, 3'd5});
    pending_keys.push_back({64'hAAAA_AAAA_AAAA_AAAA, 3'd2});
    pending_keys.push_back({64'h5555_5555_5555_5555, 3'd5});
    pending_keys.push_back({64'h5555_5555_5555_5555, 3'd5});
    pending_keys.push_back({64'h0, 3'd3});
    pending_keys.push_back({64'h4, 3'd1});
    pending_keys.push_back({ones, 3'd0});
    pending_keys.push_back({64'h2, 3'd0});

    hot_bucket[0] = '0;
    hot_bucket[1] = '1;
    for (int h = 2; h < NUM_HOT; h++) begin
      hot_bucket[h] = HASH_BITS'($urandom_range(NUM_BUCKETS - 1));
    end

    // Mostly new keys, so the table fills up well before the end and the
    // remaining traffic sees both found keys and rejections.
    for (int i = 0; i < RANDOM_KEYS; i++) begin
      pick     = $urandom_range(99);
      key.kind = CALL_KIND_W'($urandom_range(7));
      key.addr = {$urandom(), $urandom()};
      if (pick < 4) begin
        key.addr = '0;
      end else if (pick < 30 && seen_keys.size() > 0) begin
        key = seen_keys[$urandom_range(seen_keys.size() - 1)];
      end else if (pick < 42 && seen_keys.size() > 0) begin
        key.addr = seen_keys[$urandom_range(seen_keys.size() - 1)].addr;
      end else if (pick < 70) begin
        key.addr[HASH_SHIFT +: HASH_BITS] = hot_bucket[$urandom_range(NUM_HOT - 1)];
      end else if (pick < 74) begin
        key.addr = ADDR_W'($urandom_range(255));
      end
      if (key.addr != '0) seen_keys.push_back(key);
      pending_keys.push_back(key);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_keys.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
